// ----- sv/assert_macros.svh -----
// assertion helpers shared by the front and queue rtl modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// property must never hold at a clock edge outside reset
`define ASSERT_NEVER(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(prop)) else $error(msg);

`endif

// ----- sv/u2a_pkg.sv -----
// ----------------------------------------------------------------------------
// u2a_pkg
// Shared types, constants and the glyph table of the UTF-8 to ASCII mapper.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package u2a_pkg;

  localparam int CODE_W      = 21;
  localparam int QUEUE_DEPTH = 2;

  // input request: one raw byte of a line
  typedef struct packed {
    logic [7:0] in_byte;
    logic       line_end;
  } in_item_t;

  // output request: one ASCII glyph
  typedef struct packed {
    logic [6:0] glyph;
    logic       glyph_last;
  } out_item_t;

  // decoded character handed from the front to the back
  typedef struct packed {
    logic              is_ascii;
    logic [CODE_W-1:0] code;
    logic              last;
  } code_item_t;

  localparam logic [7:0] LEAD_MIN   = 8'h80;
  localparam logic [7:0] LEAD3_MIN  = 8'hE0;
  localparam logic [7:0] LEAD4_MIN  = 8'hF0;
  localparam logic [7:0] MASK_LEN2  = 8'h7F >> 2;
  localparam logic [7:0] MASK_LEN3  = 8'h7F >> 3;
  localparam logic [7:0] MASK_LEN4  = 8'h7F >> 4;
  localparam logic [CODE_W-1:0] BOX_JOIN_LO = 21'h0250C;
  localparam logic [CODE_W-1:0] BOX_JOIN_HI = 21'h0256C;

  // look-alike table for a finished code point
  function automatic logic [6:0] map_code(input logic [CODE_W-1:0] c);
    logic [6:0] g;
    case (c)
      21'h02591: g = 7'h2E;
      21'h02592: g = 7'h3A;
      21'h02593, 21'h02588: g = 7'h23;
      21'h02571: g = 7'h2F;
      21'h02572: g = 7'h5C;
      21'h02502, 21'h02503, 21'h02551: g = 7'h7C;
      21'h02500, 21'h02501, 21'h02550, 21'h02014, 21'h02013: g = 7'h2D;
      21'h000B7, 21'h02022, 21'h02027: g = 7'h2E;
      21'h02018, 21'h02019: g = 7'h27;
      21'h0201C, 21'h0201D: g = 7'h22;
      default: begin
        if (c inside {[BOX_JOIN_LO:BOX_JOIN_HI]}) g = 7'h2B;
        else g = 7'h20;
      end
    endcase
    return g;
  endfunction

endpackage

// ----- sv/u2a_front.sv -----
// ----------------------------------------------------------------------------
// u2a_front
// Accepts bytes, tracks the pending UTF-8 sequence and pushes each
// finished character (or a partial one cut by a line end) into the queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module u2a_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  u2a_pkg::in_item_t   in_data,
  input  logic                push_ready,
  output logic                push,
  output u2a_pkg::code_item_t push_data
);
  import u2a_pkg::*;

  logic [1:0]        bytes_pending;
  logic [CODE_W-1:0] code_accum;
  logic [1:0]        bytes_pending_next;
  logic [CODE_W-1:0] code_accum_next;
  logic              emit;
  logic              accept;

  assign in_ready = push_ready;
  assign accept   = in_valid && in_ready;

  // decode step for one byte
  always_comb begin
    bytes_pending_next = bytes_pending;
    code_accum_next    = code_accum;
    emit               = 1'b0;
    push_data.is_ascii = 1'b0;
    push_data.last     = in_data.line_end;
    if (bytes_pending == 2'd0) begin
      if (in_data.in_byte < LEAD_MIN) begin
        emit               = 1'b1;
        push_data.is_ascii = 1'b1;
        code_accum_next    = {{(CODE_W-8){1'b0}}, in_data.in_byte};
      end else begin
        if (in_data.in_byte >= LEAD4_MIN) begin
          code_accum_next    = {{(CODE_W-8){1'b0}}, in_data.in_byte & MASK_LEN4};
          bytes_pending_next = 2'd3;
        end else if (in_data.in_byte >= LEAD3_MIN) begin
          code_accum_next    = {{(CODE_W-8){1'b0}}, in_data.in_byte & MASK_LEN3};
          bytes_pending_next = 2'd2;
        end else begin
          code_accum_next    = {{(CODE_W-8){1'b0}}, in_data.in_byte & MASK_LEN2};
          bytes_pending_next = 2'd1;
        end
        emit = in_data.line_end;
      end
    end else begin
      code_accum_next    = {code_accum[CODE_W-7:0], in_data.in_byte[5:0]};
      bytes_pending_next = bytes_pending - 2'd1;
      emit               = (bytes_pending_next == 2'd0) || in_data.line_end;
    end
    push_data.code = code_accum_next;
  end

  assign push = accept && emit;

  // sequence state
  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_pending <= 2'd0;
      code_accum    <= '0;
    end else if (accept) begin
      if (emit) begin
        bytes_pending <= 2'd0;
        code_accum    <= '0;
      end else begin
        bytes_pending <= bytes_pending_next;
        code_accum    <= code_accum_next;
      end
    end
  end

  `ASSERT_CLK(a_line_end_clears, accept && in_data.line_end |=> bytes_pending == 2'd0 && code_accum == '0, "state not cleared after line end")
  `ASSERT_CLK(a_push_needs_accept, push |-> accept && push_ready, "push without accepted byte")
  `ASSERT_CLK(a_ascii_passes, accept && bytes_pending == 2'd0 && !in_data.in_byte[7] |-> push && push_data.is_ascii, "ascii byte not passed")

endmodule

// ----- sv/u2a_fifo.sv -----
// ----------------------------------------------------------------------------
// u2a_fifo
// Short queue of decoded characters between the front and the back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module u2a_fifo #(
  parameter int DEPTH = u2a_pkg::QUEUE_DEPTH
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                push_ready,
  input  u2a_pkg::code_item_t push_data,
  input  logic                pop,
  output logic                pop_valid,
  output u2a_pkg::code_item_t pop_data
);
  import u2a_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  code_item_t       mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign push_ready = (count != CNT_W'(DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_data   = mem[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  `ASSERT_CLK(a_count_bound, count <= CNT_W'(DEPTH), "queue count over depth")
  `ASSERT_NEVER(a_pop_empty, pop && count == '0, "pop from empty queue")
  `ASSERT_CLK(a_count_up, push && !pop |=> count == $past(count) + 1'b1, "count did not advance")

endmodule

// ----- sv/u2a_back.sv -----
// ----------------------------------------------------------------------------
// u2a_back
// Maps decoded characters to ASCII glyphs and holds them in the output
// register until taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module u2a_back (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 pop_valid,
  input  u2a_pkg::code_item_t  pop_data,
  output logic                 pop,
  output logic                 out_valid,
  input  logic                 out_ready,
  output u2a_pkg::out_item_t   out_data
);
  import u2a_pkg::*;

  logic [6:0] glyph_next;

  assign pop = pop_valid && (!out_valid || out_ready);

  // glyph lookup
  always_comb begin
    if (pop_data.is_ascii) glyph_next = pop_data.code[6:0];
    else glyph_next = map_code(pop_data.code);
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_data.glyph      <= glyph_next;
      out_data.glyph_last <= pop_data.last;
    end
  end

endmodule

// ----- sv/utf8_to_ascii_glyph_mapper.sv -----
// a character's glyph passes through a queue entry and then the output register before out_valid
// throughput: one byte per cycle, one glyph per cycle while the output is taken, set by the single-byte decode step
// ready drops only when the two-entry queue is full because the output is stalled
// reset: synchronous, active high; clears the pending sequence, queue and output valid
// no clearing pass; the block takes bytes in the cycle after reset
// ----------------------------------------------------------------------------
// utf8_to_ascii_glyph_mapper
// Decodes a UTF-8 byte stream and gives one ASCII look-alike per character.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module utf8_to_ascii_glyph_mapper #(
  parameter int QUEUE_DEPTH = u2a_pkg::QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  u2a_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output u2a_pkg::out_item_t out_data
);
  import u2a_pkg::*;

  logic       push;
  logic       push_ready;
  code_item_t push_data;
  logic       pop;
  logic       pop_valid;
  code_item_t pop_data;

  // byte decode
  u2a_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .push_ready (push_ready),
    .push       (push),
    .push_data  (push_data)
  );

  // character queue
  u2a_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop        (pop),
    .pop_valid  (pop_valid),
    .pop_data   (pop_data)
  );

  // glyph mapping and output
  u2a_back u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_data  (pop_data),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
